// File: design/cvcc_pkg.sv
// ----------------------------------------------------------------------------
// CV/CC supply regulator package
// Shared types and constants for the regulator datapath and its top level.
// ----------------------------------------------------------------------------
package cvcc_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_CURRENT      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_VOLTAGE      = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SHORT_CIRCUIT_LIMIT = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SAFE_DRIVE_LEVEL    = 2'd3;

  // Sample counter and deadband.
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] DEADBAND_COUNT = 16'd2;

  // Reset value of the safe drive level.
  localparam int SAFE_RESET = 20;

  // Status produced by the datapath for one sample.
  typedef struct packed {
    logic updated;
    logic shorted;
    logic voltage_mode;
  } cvcc_flags_t;

endpackage

// File: design/cvcc_step.sv
// ----------------------------------------------------------------------------
// CV/CC regulator step
// Combinational next-state logic for one ADC sample: slot selection,
// short-circuit check, mode selection and a clamped one-count drive step.
// ----------------------------------------------------------------------------
module cvcc_step import cvcc_pkg::*; #(
  parameter int DAC_BITS = 12,
  parameter int ADC_BITS = 10
) (
  input  logic [ADC_BITS-1:0] sample,
  input  logic                mux_phase,
  input  logic [ADC_BITS-1:0] current_reading,
  input  logic [ADC_BITS:0]   voltage_reading,
  input  logic                voltage_mode,
  input  logic                deadband,
  input  logic [DAC_BITS-1:0] drive_level,
  input  logic [ADC_BITS-1:0] target_current,
  input  logic [ADC_BITS-1:0] target_voltage,
  input  logic [ADC_BITS-1:0] short_circuit_limit,
  input  logic [DAC_BITS-1:0] safe_drive_level,
  output logic                mux_phase_next,
  output logic [ADC_BITS-1:0] current_reading_next,
  output logic [ADC_BITS:0]   voltage_reading_next,
  output logic [DAC_BITS-1:0] drive_level_next,
  output cvcc_flags_t         flags
);

  localparam int EW = ADC_BITS + 2;
  localparam logic signed [EW-1:0] ONE     = EW'(1);
  localparam logic signed [EW-1:0] MINUS_1 = -EW'(1);
  localparam logic [DAC_BITS-1:0]  DAC_MAX = {DAC_BITS{1'b1}};

  logic signed [EW-1:0] err_i;
  logic signed [EW-1:0] err_v;
  logic signed [EW-1:0] err;
  logic                 cur_mode;
  logic                 inc;
  logic                 dec;
  logic                 shorted;
  logic [DAC_BITS-1:0]  stepped;

  assign mux_phase_next       = ~mux_phase;
  assign current_reading_next = mux_phase_next ? current_reading : sample;
  assign voltage_reading_next = mux_phase_next ? {1'b0, sample} : voltage_reading;

  // The short-circuit check uses the stored current reading, even a stale one.
  assign shorted = current_reading_next > short_circuit_limit;

  assign err_i = $signed({2'b00, target_current}) - $signed({2'b00, current_reading_next});
  assign err_v = $signed({2'b00, target_voltage}) - $signed({1'b0, voltage_reading_next});

  // Current regulation holds while the current is at or above its target.
  assign cur_mode = err_i < ONE;
  assign err      = cur_mode ? err_i : err_v;

  assign inc = (err > ONE) || (!deadband && (err == ONE));
  assign dec = (err < MINUS_1) || (!deadband && (err == MINUS_1));

  always_comb begin
    stepped = drive_level;
    if (inc && (drive_level != DAC_MAX)) begin
      stepped = drive_level + DAC_BITS'(1);
    end else if (dec && (drive_level != '0)) begin
      stepped = drive_level - DAC_BITS'(1);
    end
  end

  always_comb begin
    drive_level_next   = drive_level;
    flags.updated      = 1'b0;
    flags.shorted      = 1'b0;
    flags.voltage_mode = voltage_mode;
    if (shorted) begin
      drive_level_next = safe_drive_level;
      flags.updated    = 1'b1;
      flags.shorted    = 1'b1;
    end else if (!mux_phase_next) begin
      drive_level_next   = stepped;
      flags.updated      = 1'b1;
      flags.voltage_mode = ~cur_mode;
    end
  end

endmodule

// File: design/cv_cc_supply_regulator_unit.sv
// ----------------------------------------------------------------------------
// CV/CC supply regulator unit
// Alternating current/voltage ADC samples drive a DAC regulation loop that steps
// one count per current sample, with short-circuit protection.
// ----------------------------------------------------------------------------
// A taken sample request passes through the input register and then the
// result register before its result is valid.
// Throughput: one sample per cycle while the result register is not stalled;
// the input register feeds the step logic and the result register, and the
// regulator state updates once per sample. Reset (rst, synchronous) clears
// the pipeline valids and loads the register and regulator reset values.
module cv_cc_supply_regulator_unit import cvcc_pkg::*; #(
  parameter int DAC_BITS = 12,
  parameter int ADC_BITS = 10,
  localparam int CFG_BITS = (DAC_BITS > ADC_BITS) ? DAC_BITS : ADC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  logic [ADC_BITS-1:0]       sample,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [DAC_BITS-1:0]       drive_value,
  output logic                      drive_updated,
  output logic                      in_current_limit,
  output logic                      short_circuit,
  output logic                      stored_as
);

  localparam logic [ADC_BITS:0] VOLT_RESET = {1'b1, {(ADC_BITS-1){1'b0}}, 1'b1};

  // Configuration registers.
  logic [ADC_BITS-1:0] target_current;
  logic [ADC_BITS-1:0] target_voltage;
  logic [ADC_BITS-1:0] short_circuit_limit;
  logic [DAC_BITS-1:0] safe_drive_level;

  // Regulator state.
  logic                  mux_phase;
  logic [ADC_BITS-1:0]   current_reading;
  logic [ADC_BITS:0]     voltage_reading;
  logic                  voltage_mode;
  logic [COUNT_BITS-1:0] sample_count;
  logic [DAC_BITS-1:0]   drive_level;

  // Input register.
  logic                in_valid;
  logic [ADC_BITS-1:0] in_sample;

  logic                  advance;
  logic                  process;
  logic                  mux_phase_next;
  logic [ADC_BITS-1:0]   current_reading_next;
  logic [ADC_BITS:0]     voltage_reading_next;
  logic [DAC_BITS-1:0]   drive_level_next;
  cvcc_flags_t           flags;

  // The result register is free when empty or when its request is taken.
  assign advance      = !result_valid || !result_stall;
  assign process      = in_valid && advance;
  assign sample_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_current      <= '0;
      target_voltage      <= '0;
      short_circuit_limit <= '1;
      safe_drive_level    <= DAC_BITS'(SAFE_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TARGET_CURRENT:      target_current      <= cfg_data[ADC_BITS-1:0];
        CFG_TARGET_VOLTAGE:      target_voltage      <= cfg_data[ADC_BITS-1:0];
        CFG_SHORT_CIRCUIT_LIMIT: short_circuit_limit <= cfg_data[ADC_BITS-1:0];
        CFG_SAFE_DRIVE_LEVEL:    safe_drive_level    <= cfg_data[DAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!sample_stall) begin
      in_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall && sample_valid) begin
      in_sample <= sample;
    end
  end

  cvcc_step #(
    .DAC_BITS(DAC_BITS),
    .ADC_BITS(ADC_BITS)
  ) u_step (
    .sample               (in_sample),
    .mux_phase            (mux_phase),
    .current_reading      (current_reading),
    .voltage_reading      (voltage_reading),
    .voltage_mode         (voltage_mode),
    .deadband             (sample_count > DEADBAND_COUNT),
    .drive_level          (drive_level),
    .target_current       (target_current),
    .target_voltage       (target_voltage),
    .short_circuit_limit  (short_circuit_limit),
    .safe_drive_level     (safe_drive_level),
    .mux_phase_next       (mux_phase_next),
    .current_reading_next (current_reading_next),
    .voltage_reading_next (voltage_reading_next),
    .drive_level_next     (drive_level_next),
    .flags                (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mux_phase       <= 1'b0;
      current_reading <= '0;
      voltage_reading <= VOLT_RESET;
      voltage_mode    <= 1'b0;
      sample_count    <= '0;
      drive_level     <= '0;
    end else if (process) begin
      mux_phase       <= mux_phase_next;
      current_reading <= current_reading_next;
      voltage_reading <= voltage_reading_next;
      voltage_mode    <= flags.voltage_mode;
      sample_count    <= sample_count + COUNT_BITS'(1);
      drive_level     <= drive_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      drive_value      <= drive_level_next;
      drive_updated    <= flags.updated;
      in_current_limit <= ~flags.voltage_mode;
      short_circuit    <= flags.shorted;
      stored_as        <= mux_phase_next;
    end
  end

endmodule

// File: tb/cv_cc_supply_regulator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CV/CC supply regulator unit testbench
// Sends alternating current and voltage samples through the regulator and
// checks every result against a cycle-free model of the regulation loop.
// Directed samples cover the drive limits, the short-circuit protection and
// the deadband. Random phases run under several register settings, most
// with bursty idling on both sides. A final run without idling regulates
// a drive parked mid-range.
// ----------------------------------------------------------------------------
module cv_cc_supply_regulator_unit_tb;
  import cvcc_pkg::*;

  localparam int DAC_W       = 12;
  localparam int ADC_W       = 10;
  localparam int CFG_W       = 12;
  localparam int DRIVE_MAX   = (1 << DAC_W) - 1;
  localparam int SAMPLE_MAX  = (1 << ADC_W) - 1;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [DAC_W-1:0] drive;
    logic             updated;
    logic             current_limit;
    logic             shorted;
    logic             slot;
  } regulator_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      sample_valid = 1'b0;
  logic                      sample_stall;
  logic [ADC_W-1:0]          sample = '0;
  logic                      result_valid;
  logic                      result_stall = 1'b0;
  logic [DAC_W-1:0]          drive_value;
  logic                      drive_updated;
  logic                      in_current_limit;
  logic                      short_circuit;
  logic                      stored_as;

  cv_cc_supply_regulator_unit #(
    .DAC_BITS(DAC_W),
    .ADC_BITS(ADC_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .drive_value(drive_value),
    .drive_updated(drive_updated),
    .in_current_limit(in_current_limit),
    .short_circuit(short_circuit),
    .stored_as(stored_as)
  );

  always #10 clk = ~clk;

  // Regulator settings and state as the model sees them.
  logic [ADC_W-1:0]   set_target_i;
  logic [ADC_W-1:0]   set_target_v;
  logic [ADC_W-1:0]   set_short_limit;
  logic [DAC_W-1:0]   set_safe_drive;
  logic               mux_phase;
  logic [ADC_W-1:0]   current_rd;
  logic [ADC_W:0]     voltage_rd;
  logic               voltage_mode;
  logic [COUNT_BITS-1:0] sample_count;
  logic [DAC_W-1:0]   drive_level;

  logic [ADC_W-1:0]  pending_samples[$];
  regulator_result_t predicted_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  gen_index = 0;
  bit  idle_en = 1'b1;
  bit  sample_taken = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  gap_left = 0;

  function automatic void reset_regulator();
    set_target_i    = '0;
    set_target_v    = '0;
    set_short_limit = 10'd1023;
    set_safe_drive  = DAC_W'(SAFE_RESET);
    mux_phase       = 1'b0;
    current_rd      = '0;
    voltage_rd      = 11'd1025;
    voltage_mode    = 1'b0;
    sample_count    = '0;
    drive_level     = '0;
  endfunction

  function automatic regulator_result_t regulate_sample(input logic [ADC_W-1:0] s);
    regulator_result_t r;
    int err;
    int step;
    int next_drive;
    r = '0;
    mux_phase = ~mux_phase;
    if (mux_phase) voltage_rd = {1'b0, s};
    else current_rd = s;
    // The protection looks at the stored current reading on every sample.
    if (current_rd > set_short_limit) begin
      drive_level = set_safe_drive;
      r.updated = 1'b1;
      r.shorted = 1'b1;
    end else if (!mux_phase) begin
      err = int'(set_target_i) - int'(current_rd);
      if (err < 1) begin
        voltage_mode = 1'b0;
      end else begin
        voltage_mode = 1'b1;
        err = int'(set_target_v) - int'(voltage_rd);
      end
      if (sample_count > DEADBAND_COUNT && err > -2 && err < 2) step = 0;
      else if (err > 1) step = 1;
      else if (err < -1) step = -1;
      else step = err;
      next_drive = int'(drive_level) + step;
      if (next_drive < 0) next_drive = 0;
      if (next_drive > DRIVE_MAX) next_drive = DRIVE_MAX;
      drive_level = DAC_W'(next_drive);
      r.updated = 1'b1;
    end
    sample_count = sample_count + 1'b1;
    r.drive = drive_level;
    r.current_limit = ~voltage_mode;
    r.slot = mux_phase;
    return r;
  endfunction

  function automatic int clamp_sample(input int v);
    if (v < 0) return 0;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  // Samples alternate voltage, current, voltage... from reset, so the
  // generator knows which slot each one lands in.
  function automatic logic [ADC_W-1:0] pick_sample();
    int  r;
    int  near;
    bit  is_volt;
    is_volt = (gen_index % 2) == 0;
    gen_index++;
    near = is_volt ? int'(set_target_v) : int'(set_target_i);
    r = $urandom_range(0, 99);
    if (r < 55) return ADC_W'(clamp_sample(near + int'($urandom_range(0, 4)) - 2));
    if (r < 65) return '0;
    if (r < 75) return ADC_W'(SAMPLE_MAX);
    if (r < 82 && !is_volt)
      return ADC_W'(clamp_sample(int'(set_short_limit) + int'($urandom_range(0, 3))));
    return ADC_W'($urandom);
  endfunction

  task automatic push_sample(input int v);
    pending_samples.push_back(ADC_W'(v));
    gen_index++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Upper data bits of the 10-bit registers are filled at random.
  task automatic load_settings(input int ti, input int tv, input int scl, input int safe);
    write_reg(CFG_TARGET_CURRENT, {2'($urandom), 10'(ti)});
    write_reg(CFG_TARGET_VOLTAGE, {2'($urandom), 10'(tv)});
    write_reg(CFG_SHORT_CIRCUIT_LIMIT, {2'($urandom), 10'(scl)});
    write_reg(CFG_SAFE_DRIVE_LEVEL, 12'(safe));
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || sample_valid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random_phase(input int n, input int ti, input int tv, input int scl,
                                  input int safe, input bit idle, input bit hold);
    load_settings(ti, tv, scl, safe);
    idle_en = idle;
    hold_req = hold;
    repeat (n) pending_samples.push_back(pick_sample());
    wait_drained();
  endtask

  // Config mirror and request acceptance, both sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && cfg_write) begin
      case (cfg_index)
        CFG_TARGET_CURRENT:      set_target_i    = cfg_data[ADC_W-1:0];
        CFG_TARGET_VOLTAGE:      set_target_v    = cfg_data[ADC_W-1:0];
        CFG_SHORT_CIRCUIT_LIMIT: set_short_limit = cfg_data[ADC_W-1:0];
        CFG_SAFE_DRIVE_LEVEL:    set_safe_drive  = cfg_data[DAC_W-1:0];
        default: ;
      endcase
    end
    if (!rst && sample_valid && !sample_stall) begin
      predicted_results.push_back(regulate_sample(sample));
      sample_taken = 1'b1;
    end
  end

  // Sample driver: a request holds until it is taken, then the next one
  // may follow at once or after a random gap.
  always @(negedge clk) begin
    logic             nv;
    logic [ADC_W-1:0] ns;
    nv = sample_valid;
    ns = sample;
    if (!rst && (!sample_valid || sample_taken)) begin
      sample_taken = 1'b0;
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        gap_left = $urandom_range(1, 15) - 1;
      end else if (pending_samples.size() != 0) begin
        nv = 1'b1;
        ns = pending_samples.pop_front();
      end
    end
    sample_valid <= nv;
    sample <= ns;
  end

  // Result receiver stall: random bursts, plus one long hold on request.
  always @(negedge clk) begin
    logic st;
    st = 1'b0;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      st = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      st = 1'b1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      st = 1'b1;
    end
    result_stall <= st;
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    regulator_result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: result with no request pending, actual drive %0d", $time, drive_value);
        error_count++;
      end else begin
        e = predicted_results.pop_front();
        check_field("drive_value", e.drive, drive_value);
        check_field("drive_updated", e.updated, drive_updated);
        check_field("in_current_limit", e.current_limit, in_current_limit);
        check_field("short_circuit", e.shorted, short_circuit);
        check_field("stored_as", e.slot, stored_as);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    reset_regulator();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: target current zero pulls the drive down against zero.
    push_sample(SAMPLE_MAX);
    push_sample(0);
    push_sample(5);
    push_sample(SAMPLE_MAX);
    push_sample(512);
    push_sample(1);
    wait_drained();

    // Full targets: voltage regulation steps up, short circuit forces the
    // maximum safe level, an old current reading keeps the protection on,
    // the drive saturates at the top, and the deadband holds it there.
    write_reg(CFG_TARGET_CURRENT, 12'hFFF);
    write_reg(CFG_TARGET_VOLTAGE, 12'hFFF);
    write_reg(CFG_SHORT_CIRCUIT_LIMIT, {2'b11, 10'd1000});
    write_reg(CFG_SAFE_DRIVE_LEVEL, 12'hFFF);
    push_sample(0);
    push_sample(0);
    push_sample(SAMPLE_MAX);
    push_sample(1001);
    push_sample(0);
    push_sample(1000);
    push_sample(1022);
    push_sample(999);
    push_sample(SAMPLE_MAX);
    push_sample(999);
    wait_drained();

    // All zero: any current above zero is a short with a zero safe level.
    load_settings(0, 0, 0, 0);
    push_sample(0);
    push_sample(0);
    push_sample(7);
    push_sample(3);
    push_sample(SAMPLE_MAX);
    push_sample(0);
    wait_drained();

    run_random_phase(200, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(512, 1023), $urandom_range(0, 4095), 1'b1, 1'b0);
    run_random_phase(200, 1023, 1023, 1023, 4095, 1'b1, 1'b1);
    run_random_phase(200, 0, 0, 0, 0, 1'b1, 1'b0);
    run_random_phase(200, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(256, 1023), $urandom_range(0, 4095), 1'b0, 1'b0);
    run_random_phase(200, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023), $urandom_range(0, 4095), 1'b1, 1'b0);
    run_random_phase(200, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(768, 1023), $urandom_range(0, 4095), 1'b1, 1'b0);

    // Park the drive mid-range through a short, then regulate around the
    // targets with no idling on either side.
    idle_en = 1'b0;
    load_settings(500, 600, 100, 2000);
    if (gen_index % 2 == 0) push_sample(600);
    push_sample(200);
    wait_drained();
    write_reg(CFG_SHORT_CIRCUIT_LIMIT, 12'd1023);
    repeat (60) begin
      if (gen_index % 2 == 0) push_sample(599 + $urandom_range(0, 2));
      else push_sample(499 + $urandom_range(0, 2));
    end
    wait_drained();
    repeat (10) @(negedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
